// ===== rtl/rita_pkg.sv =====
// ----------------------------------------------------------------------------
// rita_pkg: shared types and constants for the radix integer-to-ASCII block
// Widths, the microcode format, the microprogram and the digit glyph table.
// ----------------------------------------------------------------------------
package rita_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_DEPTH = 64;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

  // divider retires DIV_BITS dividend bits per cycle
  localparam int DIV_BITS = 8;
  localparam int CHUNKS   = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W    = CHUNKS * DIV_BITS;
  localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] GLYPH [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_CHECK  = 4'd1;
  localparam step_t S_DIV    = 4'd2;
  localparam step_t S_STORE  = 4'd3;
  localparam step_t S_READ   = 4'd4;
  localparam step_t S_EMIT   = 4'd5;
  localparam step_t S_LOOP   = 4'd6;
  localparam step_t S_RET    = 4'd7;
  localparam step_t S_ERR    = 4'd8;
  localparam step_t S_ERRRET = 4'd9;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD_RADIX,
    C_CHUNK_MORE,
    C_DIGIT_MORE,
    C_OUT_BUSY,
    C_COUNT_NZ
  } cond_t;

  typedef struct packed {
    logic in_ready;
    logic clr_div;
    logic div_step;
    logic store;
    logic rd;
    logic emit;
    logic emit_err;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad_radix;
    logic chunk_more;
    logic digit_more;
    logic out_busy;
    logic count_nz;
  } stat_t;

  typedef struct packed {
    ctrl_t ctl;
    cond_t cond;
    step_t target;
  } uop_t;

  localparam ctrl_t CTL_NOP = '0;

  function automatic uop_t ucode(input step_t step);
    uop_t u;
    u.ctl    = CTL_NOP;
    u.cond   = C_ALWAYS;
    u.target = S_WAIT;
    unique case (step)
      S_WAIT: begin
        u.ctl.in_ready = 1'b1;
        u.cond         = C_NO_INPUT;
        u.target       = S_WAIT;
      end
      S_CHECK: begin
        u.ctl.clr_div = 1'b1;
        u.cond        = C_BAD_RADIX;
        u.target      = S_ERR;
      end
      S_DIV: begin
        u.ctl.div_step = 1'b1;
        u.cond         = C_CHUNK_MORE;
        u.target       = S_DIV;
      end
      S_STORE: begin
        u.ctl.store   = 1'b1;
        u.ctl.clr_div = 1'b1;
        u.cond        = C_DIGIT_MORE;
        u.target      = S_DIV;
      end
      S_READ: begin
        u.ctl.rd = 1'b1;
        u.cond   = C_NONE;
      end
      S_EMIT: begin
        u.ctl.emit = 1'b1;
        u.cond     = C_OUT_BUSY;
        u.target   = S_EMIT;
      end
      S_LOOP: begin
        u.cond   = C_COUNT_NZ;
        u.target = S_READ;
      end
      S_RET, S_ERRRET: begin
        u.cond   = C_ALWAYS;
        u.target = S_WAIT;
      end
      S_ERR: begin
        u.ctl.emit_err = 1'b1;
        u.cond         = C_OUT_BUSY;
        u.target       = S_ERR;
      end
      default: begin
        u.cond   = C_ALWAYS;
        u.target = S_WAIT;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/rita_in_if.sv =====
// ----------------------------------------------------------------------------
// rita_in_if: input channel
// Valid/ready channel carrying the value to convert.
// ----------------------------------------------------------------------------
interface rita_in_if;
  logic                             valid;
  logic                             ready;
  logic [rita_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/rita_out_if.sv =====
// ----------------------------------------------------------------------------
// rita_out_if: result channel
// Valid/ready channel carrying one ASCII digit per beat, or a bad-radix error beat.
// ----------------------------------------------------------------------------
interface rita_out_if;
  logic                        valid;
  logic                        ready;
  logic [rita_pkg::CHAR_W-1:0] digit_char;
  logic                        last;
  logic                        bad_radix;

  modport source (output valid, output digit_char, output last, output bad_radix,
                  input ready);
  modport sink (input valid, input digit_char, input last, input bad_radix,
                output ready);
endinterface

// ===== rtl/rita_seq.sv =====
// ----------------------------------------------------------------------------
// rita_seq: microcode sequencer
// Step counter over the control ROM with one conditional jump per step.
// ----------------------------------------------------------------------------
module rita_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  rita_pkg::stat_t stat,
  output rita_pkg::ctrl_t ctrl
);

  rita_pkg::step_t step_r;
  rita_pkg::step_t step_nxt;
  rita_pkg::uop_t  uop;
  logic            jump;

  always_comb begin
    uop  = rita_pkg::ucode(step_r);
    ctrl = uop.ctl;
    unique case (uop.cond)
      rita_pkg::C_NONE:       jump = 1'b0;
      rita_pkg::C_ALWAYS:     jump = 1'b1;
      rita_pkg::C_NO_INPUT:   jump = !stat.in_valid;
      rita_pkg::C_BAD_RADIX:  jump = stat.bad_radix;
      rita_pkg::C_CHUNK_MORE: jump = stat.chunk_more;
      rita_pkg::C_DIGIT_MORE: jump = stat.digit_more;
      rita_pkg::C_OUT_BUSY:   jump = stat.out_busy;
      rita_pkg::C_COUNT_NZ:   jump = stat.count_nz;
      default:                jump = 1'b0;
    endcase
    step_nxt = jump ? uop.target : step_r + rita_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rita_pkg::S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/rita_dp.sv =====
// ----------------------------------------------------------------------------
// rita_dp: conversion datapath
// Radix register, chunked long divider, digit store and output register.
// ----------------------------------------------------------------------------
module rita_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rita_pkg::ctrl_t                  ctrl,
  output rita_pkg::stat_t                  stat,
  input  logic                             cfg_wr_en,
  input  logic [rita_pkg::RADIX_W-1:0]     cfg_wr_data,
  input  logic                             in_valid,
  input  logic [rita_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rita_pkg::CHAR_W-1:0]      out_char,
  output logic                             out_last,
  output logic                             out_bad
);

  logic [rita_pkg::RADIX_W-1:0] radix_r;
  logic [rita_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [rita_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [rita_pkg::CHUNK_W-1:0] chunk_r;
  logic [rita_pkg::CNT_W-1:0]   count_r;
  logic [rita_pkg::DIGIT_W-1:0] store [rita_pkg::DIGIT_DEPTH];
  logic [rita_pkg::DIGIT_W-1:0] rdata_r;
  logic [rita_pkg::CNT_W-1:0]   count_dec;
  logic                         out_valid_r;
  logic [rita_pkg::CHAR_W-1:0]  out_char_r;
  logic                         out_last_r;
  logic                         out_bad_r;
  logic                         out_free;
  logic                         accept;
  logic [rita_pkg::RADIX_W:0]   r;
  logic [rita_pkg::QUO_W-1:0]   q;

  assign accept    = in_valid && ctrl.in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign count_dec = count_r - rita_pkg::CNT_W'(1);

  // long division: DIV_BITS restoring steps per cycle, quotient shifts in place
  always_comb begin
    r = {2'b00, rem_r};
    q = quo_r;
    for (int i = 0; i < rita_pkg::DIV_BITS; i++) begin
      r = {1'b0, r[rita_pkg::DIGIT_W-1:0], q[rita_pkg::QUO_W-1]};
      q = {q[rita_pkg::QUO_W-2:0], 1'b0};
      if (r >= {1'b0, radix_r}) begin
        r    = r - {1'b0, radix_r};
        q[0] = 1'b1;
      end
    end
    quo_nxt = q;
    rem_nxt = r[rita_pkg::DIGIT_W-1:0];
  end

  always_comb begin
    stat.in_valid   = in_valid;
    stat.bad_radix  = (radix_r < rita_pkg::RADIX_MIN) || (radix_r > rita_pkg::RADIX_MAX);
    stat.chunk_more = chunk_r != rita_pkg::CHUNK_W'(rita_pkg::CHUNKS - 1);
    stat.digit_more = (quo_r != '0) &&
                      (count_r != rita_pkg::CNT_W'(rita_pkg::DIGIT_DEPTH - 1));
    stat.out_busy   = !out_free;
    stat.count_nz   = count_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= rita_pkg::RADIX_RESET;
      quo_r       <= '0;
      rem_r       <= '0;
      chunk_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (accept) begin
        quo_r   <= rita_pkg::QUO_W'(in_value);
        count_r <= '0;
      end
      if (ctrl.clr_div) begin
        rem_r   <= '0;
        chunk_r <= '0;
      end
      if (ctrl.div_step) begin
        quo_r   <= quo_nxt;
        rem_r   <= rem_nxt;
        chunk_r <= chunk_r + rita_pkg::CHUNK_W'(1);
      end
      if (ctrl.store) begin
        count_r <= count_r + rita_pkg::CNT_W'(1);
      end
      if (ctrl.rd) begin
        count_r <= count_dec;
      end
      if ((ctrl.emit || ctrl.emit_err) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      store[count_r[rita_pkg::ADDR_W-1:0]] <= rem_r;
    end
    if (ctrl.rd) begin
      rdata_r <= store[count_dec[rita_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_char_r <= rita_pkg::GLYPH[rdata_r];
      out_last_r <= count_r == '0;
      out_bad_r  <= 1'b0;
    end else if (ctrl.emit_err && out_free) begin
      out_char_r <= '0;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_bad   = out_bad_r;

endmodule

// ===== rtl/radix_int_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_int_to_ascii: unsigned integer to ASCII digits in base 2..16
// Per value with n digits: each digit takes a full pass of the 8-bit-per-cycle
// divider over all chunks of the dividend, then a store; the digits are then
// read out of the store and emitted, most significant first. A bad radix gives
// an error beat instead. A new input beat is taken only back in the wait step.
// Reset clears the sequencer, output valid, and sets radix to 10; the digit
// store is not cleared.
// ----------------------------------------------------------------------------
module radix_int_to_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  rita_in_if.sink                      in_ch,
  rita_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [rita_pkg::RADIX_W-1:0] cfg_wr_data
);

  rita_pkg::ctrl_t ctrl;
  rita_pkg::stat_t stat;

  assign in_ch.ready = ctrl.in_ready;

  rita_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rita_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.digit_char),
    .out_last    (out_ch.last),
    .out_bad     (out_ch.bad_radix)
  );

endmodule
